// ===== hdl/cau_pkg.sv =====
// Package for the complex arithmetic unit: operation codes, defaults and
// the control word that travels alongside the pipeline data. No dependencies.
`default_nettype none
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MODE_W         = 3;

    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CONJ = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [MODE_W-1:0] mode;
        logic              dz;
    } ctl_t;

endpackage
`default_nettype wire

// ===== hdl/cau_front.sv =====
// Front end: products, sums of products, sign/magnitude and saturation of
// add/sub/conj/multiply results; prepares divide operands. Uses cau_pkg.
`default_nettype none
module cau_front #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [cau_pkg::MODE_W-1:0] mode,
    input  logic [DW-1:0]             a_re,
    input  logic [DW-1:0]             a_im,
    input  logic [DW-1:0]             b_re,
    input  logic [DW-1:0]             b_im,
    output cau_pkg::ctl_t             ctl,
    output logic [DW-1:0]             smp_re,
    output logic [DW-1:0]             smp_im,
    output logic                      smp_ovf,
    output logic [DW-1:0]             mul_re,
    output logic [DW-1:0]             mul_im,
    output logic                      mul_ovf,
    output logic [2*DW+FB-1:0]        num_re,
    output logic [2*DW+FB-1:0]        num_im,
    output logic [2*DW-1:0]           den,
    output logic                      big_re,
    output logic                      big_im,
    output logic                      neg_re,
    output logic                      neg_im
);
    import cau_pkg::*;

    localparam int PW = 2 * DW;
    localparam int NW = 2 * DW + FB;
    localparam int HW = DW + FB;
    localparam int CW = (HW > PW) ? HW : PW;
    localparam logic [PW-1:0] LIM_POS = {{(DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [PW-1:0] LIM_NEG = {{(DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

    // Saturate a DW+1 bit sum to DW bits; MSB of the result is the overflow flag.
    function automatic logic [DW:0] sat_w(input logic [DW:0] v);
        logic o;
        o = v[DW] ^ v[DW-1];
        return o ? {1'b1, v[DW], {(DW-1){~v[DW]}}} : {1'b0, v[DW-1:0]};
    endfunction

    // Signed result from magnitude with saturation; MSB is the overflow flag.
    function automatic logic [DW:0] sat_sm(input logic [PW-1:0] m, input logic n);
        logic [PW-1:0] lim;
        logic [PW-1:0] v;
        logic          o;
        lim = n ? LIM_NEG : LIM_POS;
        o   = m > lim;
        v   = o ? lim : m;
        return {o, n ? -v[DW-1:0] : v[DW-1:0]};
    endfunction

    // stage 1
    ctl_t                   s1_ctl_reg, s1_ctl_next;
    logic signed [PW-1:0]   p_ac_reg, p_bd_reg, p_ad_reg, p_bc_reg, p_cc_reg, p_dd_reg;
    logic [DW-1:0]          s1_re_reg, s1_im_reg, s1_re_next, s1_im_next;
    logic                   s1_ovf_reg, s1_ovf_next;
    logic [DW:0]            sat_a, sat_b;
    // stage 2
    ctl_t                   s2_ctl_reg;
    logic [PW:0]            s2_sre_reg, s2_sim_reg, s2_sre_next, s2_sim_next;
    logic [PW-1:0]          s2_den_reg;
    logic [DW-1:0]          s2_re_reg, s2_im_reg;
    logic                   s2_ovf_reg;
    // stage 3
    ctl_t                   s3_ctl_reg, s3_ctl_next;
    logic [PW-1:0]          s3_mre_reg, s3_mim_reg, s3_den_reg;
    logic                   s3_nre_reg, s3_nim_reg;
    logic [PW:0]            neg_sre, neg_sim;
    logic [DW-1:0]          s3_re_reg, s3_im_reg;
    logic                   s3_ovf_reg;
    // stage 4
    ctl_t                   s4_ctl_reg;
    logic [DW:0]            msat_re, msat_im;
    logic [NW-1:0]          n_re, n_im;
    logic [NW-1:0]          s4_nre_reg, s4_nim_reg;
    logic [PW-1:0]          s4_den_reg;
    logic [DW-1:0]          s4_sre_reg, s4_sim_reg, s4_mre_reg, s4_mim_reg;
    logic                   s4_sovf_reg, s4_movf_reg;
    logic                   s4_bre_reg, s4_bim_reg, s4_nre_f_reg, s4_nim_f_reg;

    // Stage 1: simple operations and the six products
    always_comb
    begin
        s1_ctl_next = '{valid: in_valid, mode: mode, dz: 1'b0};
        sat_a       = '0;
        sat_b       = '0;
        s1_re_next  = '0;
        s1_im_next  = '0;
        s1_ovf_next = 1'b0;
        unique case (mode)
            MODE_ADD:
            begin
                sat_a = sat_w({a_re[DW-1], a_re} + {b_re[DW-1], b_re});
                sat_b = sat_w({a_im[DW-1], a_im} + {b_im[DW-1], b_im});
            end
            MODE_SUB:
            begin
                sat_a = sat_w({a_re[DW-1], a_re} - {b_re[DW-1], b_re});
                sat_b = sat_w({a_im[DW-1], a_im} - {b_im[DW-1], b_im});
            end
            MODE_CONJ:
            begin
                sat_a = {1'b0, a_re};
                sat_b = sat_w({(DW+1){1'b0}} - {a_im[DW-1], a_im});
            end
            default:
            begin
                sat_a = '0;
                sat_b = '0;
            end
        endcase
        s1_re_next  = sat_a[DW-1:0];
        s1_im_next  = sat_b[DW-1:0];
        s1_ovf_next = sat_a[DW] | sat_b[DW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s3_ctl_next;
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ac_reg   <= $signed(a_re) * $signed(b_re);
            p_bd_reg   <= $signed(a_im) * $signed(b_im);
            p_ad_reg   <= $signed(a_re) * $signed(b_im);
            p_bc_reg   <= $signed(a_im) * $signed(b_re);
            p_cc_reg   <= $signed(b_re) * $signed(b_re);
            p_dd_reg   <= $signed(b_im) * $signed(b_im);
            s1_re_reg  <= s1_re_next;
            s1_im_reg  <= s1_im_next;
            s1_ovf_reg <= s1_ovf_next;
        end
    end

    // Stage 2: sums of products, divisor c^2 + d^2
    always_comb
    begin
        if (s1_ctl_reg.mode == MODE_DIV)
        begin
            s2_sre_next = {p_ac_reg[PW-1], p_ac_reg} + {p_bd_reg[PW-1], p_bd_reg};
            s2_sim_next = {p_bc_reg[PW-1], p_bc_reg} - {p_ad_reg[PW-1], p_ad_reg};
        end
        else
        begin
            s2_sre_next = {p_ac_reg[PW-1], p_ac_reg} - {p_bd_reg[PW-1], p_bd_reg};
            s2_sim_next = {p_ad_reg[PW-1], p_ad_reg} + {p_bc_reg[PW-1], p_bc_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_sre_reg <= s2_sre_next;
            s2_sim_reg <= s2_sim_next;
            s2_den_reg <= p_cc_reg + p_dd_reg;
            s2_re_reg  <= s1_re_reg;
            s2_im_reg  <= s1_im_reg;
            s2_ovf_reg <= s1_ovf_reg;
        end
    end

    // Stage 3: sign and magnitude, zero divisor
    always_comb
    begin
        neg_sre     = -s2_sre_reg;
        neg_sim     = -s2_sim_reg;
        s3_ctl_next = s2_ctl_reg;
        s3_ctl_next.dz = (s2_ctl_reg.mode == MODE_DIV) && (s2_den_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_nre_reg <= s2_sre_reg[PW];
            s3_nim_reg <= s2_sim_reg[PW];
            s3_mre_reg <= s2_sre_reg[PW] ? neg_sre[PW-1:0] : s2_sre_reg[PW-1:0];
            s3_mim_reg <= s2_sim_reg[PW] ? neg_sim[PW-1:0] : s2_sim_reg[PW-1:0];
            s3_den_reg <= s2_den_reg;
            s3_re_reg  <= s2_re_reg;
            s3_im_reg  <= s2_im_reg;
            s3_ovf_reg <= s2_ovf_reg;
        end
    end

    // Stage 4: product saturation, scaled dividend, quotient range check
    always_comb
    begin
        msat_re = sat_sm(s3_mre_reg >> FB, s3_nre_reg);
        msat_im = sat_sm(s3_mim_reg >> FB, s3_nim_reg);
        n_re    = NW'(s3_mre_reg) << FB;
        n_im    = NW'(s3_mim_reg) << FB;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_mre_reg   <= msat_re[DW-1:0];
            s4_mim_reg   <= msat_im[DW-1:0];
            s4_movf_reg  <= msat_re[DW] | msat_im[DW];
            s4_nre_reg   <= n_re;
            s4_nim_reg   <= n_im;
            s4_den_reg   <= s3_den_reg;
            s4_bre_reg   <= CW'(n_re[NW-1:DW]) >= CW'(s3_den_reg);
            s4_bim_reg   <= CW'(n_im[NW-1:DW]) >= CW'(s3_den_reg);
            s4_nre_f_reg <= s3_nre_reg;
            s4_nim_f_reg <= s3_nim_reg;
            s4_sre_reg   <= s3_re_reg;
            s4_sim_reg   <= s3_im_reg;
            s4_sovf_reg  <= s3_ovf_reg;
        end
    end

    assign ctl     = s4_ctl_reg;
    assign smp_re  = s4_sre_reg;
    assign smp_im  = s4_sim_reg;
    assign smp_ovf = s4_sovf_reg;
    assign mul_re  = s4_mre_reg;
    assign mul_im  = s4_mim_reg;
    assign mul_ovf = s4_movf_reg;
    assign num_re  = s4_nre_reg;
    assign num_im  = s4_nim_reg;
    assign den     = s4_den_reg;
    assign big_re  = s4_bre_reg;
    assign big_im  = s4_bim_reg;
    assign neg_re  = s4_nre_f_reg;
    assign neg_im  = s4_nim_f_reg;

endmodule
`default_nettype wire

// ===== hdl/cau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, DW stages.
// Quotient assumed below 2^DW (range checked upstream). Uses cau_pkg.
`default_nettype none
module cau_div #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [2*DW+FB-1:0]   num,
    input  logic [2*DW-1:0]      den,
    output logic [DW-1:0]        quo
);
    import cau_pkg::*;

    localparam int PW = 2 * DW;
    localparam int NW = 2 * DW + FB;

    logic [PW-1:0] rem_reg [DW];
    logic [PW-1:0] den_reg [DW];
    logic [DW-1:0] nlo_reg [DW];
    logic [DW-1:0] q_reg   [DW];

    genvar k;
    generate
        for (k = 0; k < DW; k++)
        begin : g_stage
            logic [PW-1:0] rem_in, den_in, trial;
            logic [DW-1:0] nlo_in, q_in;
            logic          ge;
            if (k == 0)
            begin : g_first
                assign rem_in = PW'(num[NW-1:DW]);
                assign den_in = den;
                assign nlo_in = num[DW-1:0];
                assign q_in   = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign nlo_in = nlo_reg[k-1];
                assign q_in   = q_reg[k-1];
            end
            assign trial = {rem_in[PW-2:0], nlo_in[DW-1]};
            assign ge    = trial >= den_in;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? trial - den_in : trial;
                    den_reg[k] <= den_in;
                    nlo_reg[k] <= nlo_in << 1;
                    q_reg[k]   <= {q_in[DW-2:0], ge};
                end
            end
        end
    endgenerate

    assign quo = q_reg[DW-1];

endmodule
`default_nettype wire

// ===== hdl/cau_back.sv =====
// Result select, quotient sign/saturation and the output register.
// Uses cau_pkg.
`default_nettype none
module cau_back #(
    parameter int DW = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  cau_pkg::ctl_t  ctl,
    input  logic [DW-1:0]  smp_re,
    input  logic [DW-1:0]  smp_im,
    input  logic           smp_ovf,
    input  logic [DW-1:0]  mul_re,
    input  logic [DW-1:0]  mul_im,
    input  logic           mul_ovf,
    input  logic [DW-1:0]  quo_re,
    input  logic [DW-1:0]  quo_im,
    input  logic           big_re,
    input  logic           big_im,
    input  logic           neg_re,
    input  logic           neg_im,
    output logic           out_valid,
    output logic [DW-1:0]  res_re,
    output logic [DW-1:0]  res_im,
    output logic           overflow,
    output logic           div_zero
);
    import cau_pkg::*;

    localparam logic [DW-1:0] LIM_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] LIM_NEG = {1'b1, {(DW-1){1'b0}}};

    function automatic logic [DW:0] qsat(input logic [DW-1:0] q, input logic b,
                                         input logic n);
        logic [DW-1:0] lim;
        logic [DW-1:0] v;
        logic          o;
        lim = n ? LIM_NEG : LIM_POS;
        o   = b || (q > lim);
        v   = o ? lim : q;
        return {o, n ? -v : v};
    endfunction

    logic          valid_reg;
    logic [DW-1:0] re_reg, im_reg, re_next, im_next;
    logic          ovf_reg, ovf_next, dz_reg;
    logic [DW:0]   dq_re, dq_im;

    always_comb
    begin
        dq_re    = qsat(quo_re, big_re, neg_re);
        dq_im    = qsat(quo_im, big_im, neg_im);
        re_next  = '0;
        im_next  = '0;
        ovf_next = 1'b0;
        unique case (ctl.mode)
            MODE_ADD, MODE_SUB, MODE_CONJ:
            begin
                re_next  = smp_re;
                im_next  = smp_im;
                ovf_next = smp_ovf;
            end
            MODE_MUL:
            begin
                re_next  = mul_re;
                im_next  = mul_im;
                ovf_next = mul_ovf;
            end
            MODE_DIV:
            begin
                if (!ctl.dz)
                begin
                    re_next  = dq_re[DW-1:0];
                    im_next  = dq_im[DW-1:0];
                    ovf_next = dq_re[DW] | dq_im[DW];
                end
            end
            default:
            begin
                re_next  = '0;
                im_next  = '0;
                ovf_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            ovf_reg <= ovf_next;
            dz_reg  <= ctl.dz;
        end
    end

    assign out_valid = valid_reg;
    assign res_re    = re_reg;
    assign res_im    = im_reg;
    assign overflow  = ovf_reg;
    assign div_zero  = dz_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && dz_reg |-> re_reg == '0 && im_reg == '0 && !ovf_reg)
        else $error("zero divisor result not cleared");

    a_dz_mode: assert property (@(posedge clk) disable iff (!rst_n)
        en && ctl.valid && ctl.dz |-> ctl.mode == MODE_DIV)
        else $error("zero divisor flag outside divide");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !en |=> valid_reg && $stable(re_reg) && $stable(im_reg))
        else $error("output register changed while stalled");

endmodule
`default_nettype wire

// ===== hdl/complex_arithmetic_unit_top.sv =====
// Complex ALU: add, subtract, multiply, divide, conjugate on signed fixed point.
// The pipeline depth is set by the one quotient bit per stage of the divider.
// Throughput: one transaction per cycle while the output is not stalled.
// Backpressure freezes the whole pipeline; reset clears only the control bits.
// Depends on cau_pkg, cau_front, cau_div, cau_back.
`default_nettype none
module complex_arithmetic_unit_top #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // a_re, a_im, b_re, b_im (lowest first), zero padded to bytes
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]             s_tdata,
    // mode
    input  logic [cau_pkg::MODE_W-1:0]                    s_tuser,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // res_re, res_im (lowest first), zero padded to bytes
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]             m_tdata,
    // overflow, div_zero (lowest first)
    output logic [1:0]                                    m_tuser
);
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int OW = ((2*DATA_WIDTH+7)/8)*8;
    // side data carried past the divider: simple, product and sign/range bits
    localparam int SW = 4*DW + 6;

    logic          en;
    ctl_t          f_ctl;
    logic [DW-1:0] f_sre, f_sim, f_mre, f_mim;
    logic          f_sovf, f_movf, f_bre, f_bim, f_nre, f_nim;
    logic [2*DW+FB-1:0] f_numre, f_numim;
    logic [2*DW-1:0]    f_den;
    logic [DW-1:0] quo_re, quo_im;
    logic [SW-1:0] side_in;
    ctl_t          ctl_reg  [DW];
    logic [SW-1:0] side_reg [DW];
    logic [SW-1:0] side_out;
    logic          out_valid, ovf, dz;
    logic [DW-1:0] res_re, res_im;

    // The pipeline moves whenever the output register is empty or being taken.
    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    cau_front #(.DW(DW), .FB(FB)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .mode     (s_tuser),
        .a_re     (s_tdata[DW-1:0]),
        .a_im     (s_tdata[2*DW-1:DW]),
        .b_re     (s_tdata[3*DW-1:2*DW]),
        .b_im     (s_tdata[4*DW-1:3*DW]),
        .ctl      (f_ctl),
        .smp_re   (f_sre),
        .smp_im   (f_sim),
        .smp_ovf  (f_sovf),
        .mul_re   (f_mre),
        .mul_im   (f_mim),
        .mul_ovf  (f_movf),
        .num_re   (f_numre),
        .num_im   (f_numim),
        .den      (f_den),
        .big_re   (f_bre),
        .big_im   (f_bim),
        .neg_re   (f_nre),
        .neg_im   (f_nim)
    );

    // Two quotient lanes share the divisor.
    cau_div #(.DW(DW), .FB(FB)) u_div_re (
        .clk (clk),
        .en  (en),
        .num (f_numre),
        .den (f_den),
        .quo (quo_re)
    );

    cau_div #(.DW(DW), .FB(FB)) u_div_im (
        .clk (clk),
        .en  (en),
        .num (f_numim),
        .den (f_den),
        .quo (quo_im)
    );

    // Delay line keeping control and side results aligned with the divider.
    assign side_in = {f_nim, f_nre, f_bim, f_bre, f_movf, f_mim, f_mre,
                      f_sovf, f_sim, f_sre};

    genvar k;
    generate
        for (k = 0; k < DW; k++)
        begin : g_side
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    ctl_reg[k] <= '0;
                else if (en)
                    ctl_reg[k] <= (k == 0) ? f_ctl : ctl_reg[(k == 0) ? 0 : k-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    side_reg[k] <= (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    endgenerate

    assign side_out = side_reg[DW-1];

    cau_back #(.DW(DW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl       (ctl_reg[DW-1]),
        .smp_re    (side_out[DW-1:0]),
        .smp_im    (side_out[2*DW-1:DW]),
        .smp_ovf   (side_out[2*DW]),
        .mul_re    (side_out[3*DW:2*DW+1]),
        .mul_im    (side_out[4*DW:3*DW+1]),
        .mul_ovf   (side_out[4*DW+1]),
        .quo_re    (quo_re),
        .quo_im    (quo_im),
        .big_re    (side_out[4*DW+2]),
        .big_im    (side_out[4*DW+3]),
        .neg_re    (side_out[4*DW+4]),
        .neg_im    (side_out[4*DW+5]),
        .out_valid (out_valid),
        .res_re    (res_re),
        .res_im    (res_im),
        .overflow  (ovf),
        .div_zero  (dz)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = OW'({res_im, res_re});
    assign m_tuser  = {dz, ovf};

endmodule
`default_nettype wire

// ===== test/complex_arithmetic_unit_top_test.sv =====
// Self-checking testbench for complex_arithmetic_unit_top: a directed table, then random
// operand pairs, each result checked against a typed-in answer or an in-bench fixed-point complex predictor.
// Depends on cau_pkg and the complex_arithmetic_unit_top RTL.
`default_nettype none
module complex_arithmetic_unit_top_test;
    import cau_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam int LATENCY = DW + 5;
    localparam int NUM_RANDOM = 1600;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DW-1:0]     a_re;
        logic [DW-1:0]     a_im;
        logic [DW-1:0]     b_re;
        logic [DW-1:0]     b_im;
    } operands_t;

    typedef struct packed {
        logic [DW-1:0] res_re;
        logic [DW-1:0] res_im;
        logic          overflow;
        logic          div_zero;
    } answer_t;

    // one directed row: operands, plus a typed-in answer where it is obvious
    typedef struct packed {
        operands_t ops;
        logic      has_answer;
        answer_t   answer;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [4*DW-1:0]       s_tdata;
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [2*DW-1:0]       m_tdata;
    logic [1:0]            m_tuser;

    complex_arithmetic_unit_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    answer_t pending_answers[$];
    int      error_count;
    int      results_seen;
    int      ops_count[8];

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic longint clamp(input longint v, inout logic ovf);
        if (v > SMAX)
        begin
            ovf = 1'b1;
            return SMAX;
        end
        if (v < SMIN)
        begin
            ovf = 1'b1;
            return SMIN;
        end
        return v;
    endfunction

    // signed sum of two exact products, truncated by the fraction shift, saturated
    function automatic longint product_part(input longint p, input longint q,
                                            inout logic ovf);
        logic signed [65:0] sum;
        logic        [65:0] mag;
        logic        [65:0] lim;
        logic               neg;
        sum = 66'(signed'(p)) + 66'(signed'(q));
        neg = sum[65];
        mag = neg ? -sum : sum;
        mag = mag >> FB;                // truncate toward zero on the magnitude
        lim = neg ? 66'(SMAX) + 1 : 66'(SMAX);
        if (mag > lim)
        begin
            ovf = 1'b1;
            mag = lim;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // (p+q) << FB divided by den, truncated toward zero, saturated
    function automatic longint quotient_part(input longint p, input longint q,
                                             input logic [63:0] den, inout logic ovf);
        logic signed [65:0]  sum;
        logic        [127:0] num;
        logic        [127:0] quo;
        logic        [127:0] lim;
        logic                neg;
        sum = 66'(signed'(p)) + 66'(signed'(q));
        neg = sum[65];
        num = 128'(neg ? -sum : sum) << FB;
        quo = num / 128'(den);
        lim = neg ? 128'(SMAX) + 1 : 128'(SMAX);
        if (quo > lim)
        begin
            ovf = 1'b1;
            quo = lim;
        end
        return neg ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic answer_t predict_complex(input operands_t op);
        answer_t   r;
        longint    a;
        longint    b;
        longint    c;
        longint    d;
        longint    re;
        longint    im;
        logic      ovf;
        logic [63:0] den;
        a = longint'(signed'(op.a_re));
        b = longint'(signed'(op.a_im));
        c = longint'(signed'(op.b_re));
        d = longint'(signed'(op.b_im));
        re = 0;
        im = 0;
        ovf = 1'b0;
        r = '0;
        case (op.mode)
            MODE_ADD:
            begin
                re = clamp(a + c, ovf);
                im = clamp(b + d, ovf);
            end
            MODE_SUB:
            begin
                re = clamp(a - c, ovf);
                im = clamp(b - d, ovf);
            end
            MODE_MUL:
            begin
                re = product_part(a * c, -(b * d), ovf);
                im = product_part(a * d, b * c, ovf);
            end
            MODE_DIV:
            begin
                den = 64'(c * c) + 64'(d * d);
                if (den == 0)
                    r.div_zero = 1'b1;
                else
                begin
                    re = quotient_part(a * c, b * d, den, ovf);
                    im = quotient_part(b * c, -(a * d), den, ovf);
                end
            end
            MODE_CONJ:
            begin
                re = a;
                im = clamp(-b, ovf);
            end
            default:
            begin
            end
        endcase
        r.res_re = re[DW-1:0];
        r.res_im = im[DW-1:0];
        r.overflow = ovf;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Directed stimulus table
    // ---------------------------------------------------------------------
    localparam logic [DW-1:0] MAXP = 32'h7fffffff;
    localparam logic [DW-1:0] MINN = 32'h80000000;
    localparam logic [DW-1:0] ONE  = 32'h00010000;
    localparam logic [DW-1:0] NONE = 32'hffff0000;   // -1.0

    function automatic row_t mk_row(input logic [MODE_W-1:0] m, input logic [DW-1:0] ar,
                                    input logic [DW-1:0] ai, input logic [DW-1:0] br,
                                    input logic [DW-1:0] bi, input logic has,
                                    input logic [DW-1:0] rr, input logic [DW-1:0] ri,
                                    input logic ov, input logic dz);
        row_t row;
        row.ops = '{m, ar, ai, br, bi};
        row.has_answer = has;
        row.answer = '{rr, ri, ov, dz};
        return row;
    endfunction

    row_t directed_rows[$];

    task automatic build_directed_table();
        // add: zeros, positive and negative saturation
        directed_rows.push_back(mk_row(MODE_ADD, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(MODE_ADD, MAXP, MINN, 1, 32'hffffffff,
                                       1'b1, MAXP, MINN, 1'b1, 1'b0));
        directed_rows.push_back(mk_row(MODE_ADD, MAXP, MINN, 0, 0, 1'b1, MAXP, MINN,
                                       1'b0, 1'b0));
        // subtract across the extremes
        directed_rows.push_back(mk_row(MODE_SUB, MINN, MAXP, 1, 32'hffffffff,
                                       1'b1, MINN, MAXP, 1'b1, 1'b0));
        directed_rows.push_back(mk_row(MODE_SUB, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f,
                                       32'hf0f0f0f0, 1'b0, 0, 0, 1'b0, 1'b0));
        // multiply: 1*1, j*j, extremes
        directed_rows.push_back(mk_row(MODE_MUL, ONE, 0, ONE, 0, 1'b1, ONE, 0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(MODE_MUL, 0, ONE, 0, ONE, 1'b1, NONE, 0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(MODE_MUL, MINN, MINN, MINN, MINN, 1'b0, 0, 0,
                                       1'b0, 1'b0));
        directed_rows.push_back(mk_row(MODE_MUL, MAXP, MAXP, MAXP, MINN, 1'b0, 0, 0,
                                       1'b0, 1'b0));
        directed_rows.push_back(mk_row(MODE_MUL, 32'hfffffffd, 32'h00000003, 32'h00007fff,
                                       32'hffff8001, 1'b0, 0, 0, 1'b0, 1'b0));
        // divide: zero divisor with nonzero and extreme numerators, then unit, extreme and mixed divisors
        directed_rows.push_back(mk_row(MODE_DIV, ONE, ONE, 0, 0, 1'b1, 0, 0, 1'b0, 1'b1));
        directed_rows.push_back(mk_row(MODE_DIV, MINN, MAXP, 0, 0, 1'b1, 0, 0, 1'b0, 1'b1));
        directed_rows.push_back(mk_row(MODE_DIV, ONE, 0, ONE, 0, 1'b1, ONE, 0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(MODE_DIV, MAXP, MINN, 1, 0, 1'b0, 0, 0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(MODE_DIV, MINN, MINN, MINN, MINN, 1'b0, 0, 0,
                                       1'b0, 1'b0));
        directed_rows.push_back(mk_row(MODE_DIV, 32'h00000005, 32'hfffffffb, 32'h00030000,
                                       32'hfffd0000, 1'b0, 0, 0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(MODE_DIV, MAXP, MAXP, 0, 1, 1'b0, 0, 0, 1'b0, 1'b0));
        // conjugate, including negating the most negative value
        directed_rows.push_back(mk_row(MODE_CONJ, MINN, MINN, MAXP, MAXP,
                                       1'b1, MINN, MAXP, 1'b1, 1'b0));
        directed_rows.push_back(mk_row(MODE_CONJ, MAXP, MAXP, 0, 0, 1'b1, MAXP,
                                       32'h80000001, 1'b0, 1'b0));
        // unused modes return all zeros
        directed_rows.push_back(mk_row(3'd5, MAXP, MAXP, MAXP, MAXP, 1'b1, 0, 0,
                                       1'b0, 1'b0));
        directed_rows.push_back(mk_row(3'd6, MINN, ONE, ONE, ONE, 1'b1, 0, 0, 1'b0, 1'b0));
        directed_rows.push_back(mk_row(3'd7, 32'hffffffff, 32'hffffffff, 0, 0,
                                       1'b1, 0, 0, 1'b0, 1'b0));
    endtask

    // ---------------------------------------------------------------------
    // Random operands: mostly the five real operations, with a mix of
    // small values, extremes and full-range words so every bit toggles.
    // ---------------------------------------------------------------------
    function automatic logic [DW-1:0] random_word();
        case ($urandom_range(0, 5))
            0:       return DW'($urandom_range(0, 32'h3ffff)) - 32'h20000;
            1:       return $urandom_range(0, 1) ? MAXP : MINN;
            2:       return DW'($urandom_range(0, 3)) * ONE - 32'h20000;
            3:       return DW'($urandom) >>> $urandom_range(0, 30);
            default: return $urandom;
        endcase
    endfunction

    function automatic operands_t random_operands();
        operands_t op;
        op.mode = ($urandom_range(0, 19) == 0) ? MODE_W'($urandom_range(5, 7))
                                               : MODE_W'($urandom_range(0, 4));
        op.a_re = random_word();
        op.a_im = random_word();
        op.b_re = random_word();
        op.b_im = random_word();
        // exercise the zero divisor now and then
        if (op.mode == MODE_DIV && $urandom_range(0, 15) == 0)
        begin
            op.b_re = 0;
            op.b_im = 0;
        end
        return op;
    endfunction

    // ---------------------------------------------------------------------
    // Sender: bursts of random length with random gaps; drives on falling edge
    // ---------------------------------------------------------------------
    int burst_left;

    task automatic send_transaction(input operands_t op, input answer_t ans);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op.mode;
        s_tdata  <= {op.b_im, op.b_re, op.a_im, op.a_re};
        // the expectation enters the queue at the accepting edge
        do
            @(posedge clk);
        while (!s_tready);
        pending_answers.push_back(ans);
        ops_count[op.mode]++;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Receiver: stall pattern of its own, with stall-free stretches
    // ---------------------------------------------------------------------
    int stall_phase;

    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[8:7] == 2'b11)
            m_tready <= 1'b1;                    // stretch with no stalls
        else if (stall_phase[6])
            m_tready <= ($urandom_range(0, 3) != 0);
        else
            m_tready <= (stall_phase[2:0] != 3'd5) && ($urandom_range(0, 9) != 0);
    end

    // ---------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            answer_t want;
            results_seen++;
            if (pending_answers.size() == 0)
            begin
                $error("result with no transaction pending: tdata=%h tuser=%b",
                       m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_tdata[DW-1:0] !== want.res_re)
                begin
                    $error("res_re: expected %h, actual %h", want.res_re, m_tdata[DW-1:0]);
                    error_count++;
                end
                if (m_tdata[2*DW-1:DW] !== want.res_im)
                begin
                    $error("res_im: expected %h, actual %h", want.res_im,
                           m_tdata[2*DW-1:DW]);
                    error_count++;
                end
                if (m_tuser[0] !== want.overflow)
                begin
                    $error("overflow: expected %b, actual %b", want.overflow, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== want.div_zero)
                begin
                    $error("div_zero: expected %b, actual %b", want.div_zero, m_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        operands_t op;
        answer_t   ans;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        stall_phase = 0;
        burst_left  = 0;
        error_count = 0;
        results_seen = 0;
        foreach (ops_count[i]) ops_count[i] = 0;
        build_directed_table();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows: typed-in answers are cross-checked against the predictor
        foreach (directed_rows[i])
        begin
            op  = directed_rows[i].ops;
            ans = predict_complex(op);
            if (directed_rows[i].has_answer && ans !== directed_rows[i].answer)
            begin
                $error("directed row %0d: table %h, predictor %h", i,
                       directed_rows[i].answer, ans);
                error_count++;
            end
            send_transaction(op, directed_rows[i].has_answer ? directed_rows[i].answer
                                                             : ans);
        end

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            op = random_operands();
            send_transaction(op, predict_complex(op));
        end
        s_tvalid <= 1'b0;

        wait (pending_answers.size() == 0);
        repeat (4 * LATENCY) @(posedge clk);

        $display("Covered %0d results: add %0d, sub %0d, mul %0d, div %0d, conj %0d,",
                 results_seen, ops_count[0], ops_count[1], ops_count[2], ops_count[3],
                 ops_count[4]);
        $display("  unused modes %0d, under random source gaps and sink stalls",
                 ops_count[5] + ops_count[6] + ops_count[7]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: generous bound on the slowest legal run
    initial
    begin
        #(12 * 400000);
        $display("timeout: %0d transactions still pending", pending_answers.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

// ===== complex_arithmetic_unit_top.f =====
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_div.sv
hdl/cau_back.sv
hdl/complex_arithmetic_unit_top.sv
test/complex_arithmetic_unit_top_test.sv
